@@ src/hht_pkg.sv @@
`default_nettype none

package hht_pkg;

  // Width of the decimal accumulator; the reported value is cut to NUMERIC_W bits
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned NUMERIC_W   = 16;
  localparam int unsigned PHASE_W     = 4;

  // Field phases, also used as the field tag of a result
  localparam logic [PHASE_W-1:0] PH_METHOD = 4'd0;
  localparam logic [PHASE_W-1:0] PH_URI    = 4'd1;
  localparam logic [PHASE_W-1:0] PH_QUERY  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_PROTO  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_MAJOR  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_MINOR  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_STATUS = 4'd6;
  localparam logic [PHASE_W-1:0] PH_TEXT   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_KEY    = 4'd8;
  localparam logic [PHASE_W-1:0] PH_VALUE  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_BODY   = 4'd10;

  // Message kinds
  localparam logic KIND_REQUEST  = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // Delimiter characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};

  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic                   cr_seen;
    logic                   in_query;
    logic [VALUE_WIDTH-1:0] acc;
    logic                   stopped;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [3:0]           field_tag;
    logic                 is_content;
    logic [NUMERIC_W-1:0] numeric_value;
    logic                 headers_complete;
  } token_t;

endpackage

`default_nettype wire

@@ src/hht_in_if.sv @@
`default_nettype none

interface hht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_message;

  modport source (output valid, output in_byte, output start_of_message, input ready);
  modport sink   (input valid, input in_byte, input start_of_message, output ready);
endinterface

`default_nettype wire

@@ src/hht_out_if.sv @@
`default_nettype none

interface hht_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [3:0]  field_tag;
  logic        is_content;
  logic [15:0] numeric_value;
  logic        headers_complete;

  modport source (output valid, output out_byte, output field_tag, output is_content,
                  output numeric_value, output headers_complete, input ready);
  modport sink   (input valid, input out_byte, input field_tag, input is_content,
                  input numeric_value, input headers_complete, output ready);
endinterface

`default_nettype wire

@@ src/http_header_tokenizer.sv @@
`default_nettype none

// Channel   Dir  Payload                                                    Transfer
// in_i      in   in_byte[8], start_of_message[1]                           valid & ready
// out_o     out  out_byte[8], field_tag[4], is_content[1],
//                numeric_value[16], headers_complete[1]                    valid & ready
// cfg       in   cfg_wr_data_i[1] = message_kind                            cfg_wr_en_i
//
// One byte per cycle: each accepted byte updates the parse state in the same
// cycle, and its token (if any) lands in the output register on that edge.
// The output register frees on the transfer that drains it, so a byte is taken
// while a token waits, as long as out_o.ready is high. Before the body, CR, stray
// LF and CR LF outside the known end-of-line phases produce no token.
// Reset clears the parse state to the method phase and message_kind to request.

module http_header_tokenizer
  import hht_pkg::*;
(
  input  var logic     clk_i,
  input  var logic     rst_ni,
  input  var logic     cfg_wr_en_i,
  input  var logic     cfg_wr_data_i,
  hht_in_if.sink       in_i,
  hht_out_if.source    out_o
);

  logic         kind_q;
  parse_state_t state_q;
  parse_state_t state_d;
  logic         emit;
  token_t       token;
  token_t       token_q;
  logic         out_valid_q;
  logic         in_fire;

  // Take a new byte whenever the output register is empty or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  hht_step u_step (
    .state_i   (state_q),
    .kind_i    (kind_q),
    .byte_i    (in_i.in_byte),
    .restart_i (in_i.start_of_message),
    .state_o   (state_d),
    .emit_o    (emit),
    .token_o   (token)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_REQUEST;
    end else if (cfg_wr_en_i) begin
      kind_q <= cfg_wr_data_i;
    end
  end

  // Advance the parse state on every accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_METHOD, cr_seen: 1'b0, in_query: 1'b0,
                   acc: '0, stopped: 1'b0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output register: drop on transfer, load when the byte yields a token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      token_q <= token;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.out_byte         = token_q.out_byte;
  assign out_o.field_tag        = token_q.field_tag;
  assign out_o.is_content       = token_q.is_content;
  assign out_o.numeric_value    = token_q.numeric_value;
  assign out_o.headers_complete = token_q.headers_complete;

endmodule

`default_nettype wire

@@ src/hht_step.sv @@
`default_nettype none

module hht_step
  import hht_pkg::*;
(
  input  var parse_state_t state_i,
  input  var logic         kind_i,
  input  var logic [7:0]   byte_i,
  input  var logic         restart_i,
  output parse_state_t     state_o,
  output logic             emit_o,
  output token_t           token_o
);

  parse_state_t             st;
  logic                     end_hit;
  logic [PHASE_W-1:0]       end_next;
  logic                     end_done;
  logic                     content_hit;
  logic [PHASE_W-1:0]       content_tag;
  logic                     acc_en;
  logic                     is_digit;
  logic [VALUE_WIDTH+3:0]   acc_ext;
  logic                     numeric;

  // Restart takes effect before the byte is handled
  always_comb begin
    st = state_i;
    if (restart_i) begin
      st.phase    = (kind_i == KIND_RESPONSE) ? PH_PROTO : PH_METHOD;
      st.in_query = 1'b0;
      st.acc      = '0;
      st.stopped  = 1'b0;
    end
  end

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign acc_ext  = ({4'b0000, st.acc} << 3) + ({4'b0000, st.acc} << 1)
                  + {{VALUE_WIDTH{1'b0}}, byte_i[3:0]};
  assign numeric  = (st.phase == PH_MAJOR) || (st.phase == PH_MINOR) ||
                    (st.phase == PH_STATUS);

  always_comb begin
    end_hit     = 1'b0;
    end_next    = st.phase;
    end_done    = 1'b0;
    content_hit = 1'b0;
    content_tag = st.phase;
    acc_en      = 1'b0;
    state_o     = st;

    if (st.phase >= PH_BODY) begin
      content_hit = 1'b1;
      content_tag = PH_BODY;
    end else if (byte_i == CH_CR) begin
      state_o.cr_seen = 1'b1;
    end else if (byte_i == CH_LF) begin
      if (st.cr_seen) begin
        if ((st.phase == PH_MINOR && kind_i == KIND_REQUEST) ||
            st.phase == PH_TEXT || st.phase == PH_VALUE) begin
          end_hit  = 1'b1;
          end_next = PH_KEY;
        end else if (st.phase == PH_KEY) begin
          end_hit  = 1'b1;
          end_next = PH_BODY;
          end_done = 1'b1;
        end
      end
    end else begin
      content_hit = 1'b1;
      case (st.phase)
        PH_METHOD: begin
          if (byte_i == CH_SPACE) begin
            end_hit  = 1'b1;
            end_next = PH_URI;
          end
        end
        PH_URI: begin
          if (byte_i == CH_SPACE) begin
            end_hit  = 1'b1;
            end_next = PH_PROTO;
          end else if (byte_i == CH_QMARK && !st.in_query) begin
            end_hit  = 1'b1;
            end_next = PH_QUERY;
            state_o.in_query = 1'b1;
          end
        end
        PH_QUERY: begin
          if (byte_i == CH_SPACE) begin
            end_hit  = 1'b1;
            end_next = PH_PROTO;
          end
        end
        PH_PROTO: begin
          if (byte_i == CH_SLASH) begin
            end_hit  = 1'b1;
            end_next = PH_MAJOR;
          end
        end
        PH_MAJOR: begin
          if (byte_i == CH_DOT) begin
            end_hit  = 1'b1;
            end_next = PH_MINOR;
          end else begin
            acc_en = 1'b1;
          end
        end
        PH_MINOR: begin
          if (byte_i == CH_SPACE && kind_i == KIND_RESPONSE) begin
            end_hit  = 1'b1;
            end_next = PH_STATUS;
          end else begin
            acc_en = 1'b1;
          end
        end
        PH_STATUS: begin
          if (byte_i == CH_SPACE) begin
            end_hit  = 1'b1;
            end_next = PH_TEXT;
          end else begin
            acc_en = 1'b1;
          end
        end
        PH_KEY: begin
          if (byte_i == CH_COLON) begin
            end_hit  = 1'b1;
            end_next = PH_VALUE;
          end
        end
        default: ;
      endcase
    end

    // Digits build the value until the first non-digit of the field
    if (acc_en && !st.stopped) begin
      if (is_digit) begin
        if (acc_ext > {4'b0000, VALUE_MAX}) begin
          state_o.acc = VALUE_MAX;
        end else begin
          state_o.acc = acc_ext[VALUE_WIDTH-1:0];
        end
      end else begin
        state_o.stopped = 1'b1;
      end
    end

    token_o = '0;
    emit_o  = 1'b0;
    if (end_hit) begin
      emit_o                   = 1'b1;
      token_o.field_tag        = st.phase;
      token_o.numeric_value    = numeric ? NUMERIC_W'(st.acc) : '0;
      token_o.headers_complete = end_done;
      state_o.phase            = end_next;
      state_o.acc              = '0;
      state_o.stopped          = 1'b0;
    end else if (content_hit) begin
      emit_o             = 1'b1;
      token_o.out_byte   = byte_i;
      token_o.field_tag  = content_tag;
      token_o.is_content = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ bench/http_header_tokenizer_checker.sv @@
`timescale 1ns / 1ps

module http_header_tokenizer_checker
  import hht_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        cfg_wr_en_i,
  input  var logic        cfg_wr_data_i,
  hht_in_if               byte_mon,
  hht_out_if              token_mon,
  output int unsigned     pending_o,
  output int unsigned     errors_o
);

  // Predicted parser state, kept in step with the accepted bytes
  logic                   kind_q;
  logic [PHASE_W-1:0]     phase_q;
  logic                   cr_seen_q;
  logic                   in_query_q;
  logic [VALUE_WIDTH-1:0] acc_q;
  logic                   stopped_q;

  token_t      expected_tokens[$];
  int unsigned err_count = 0;

  // Add one byte to the version or status value; freeze on the first non-digit
  function automatic void add_digit(input logic [7:0] b);
    longint unsigned v;
    if (stopped_q) return;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      v = 64'(acc_q) * 64'd10 + 64'(b - CH_ZERO);
      if (v > 64'(VALUE_MAX)) v = 64'(VALUE_MAX);
      acc_q = v[VALUE_WIDTH-1:0];
    end else begin
      stopped_q = 1'b1;
    end
  endfunction

  // Advance the parser by one byte; return 1 with the token when one is due
  function automatic bit tokenize_byte(input logic [7:0] b, input logic restart,
                                       output token_t tok);
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] next_ph;
    logic               ends;
    logic               done;
    tok     = '0;
    ends    = 1'b0;
    done    = 1'b0;
    next_ph = PH_BODY;
    if (restart) begin
      phase_q    = (kind_q == KIND_RESPONSE) ? PH_PROTO : PH_METHOD;
      in_query_q = 1'b0;
      acc_q      = '0;
      stopped_q  = 1'b0;
    end
    ph = phase_q;
    if (ph >= PH_BODY) begin
      tok.out_byte   = b;
      tok.field_tag  = PH_BODY;
      tok.is_content = 1'b1;
      return 1'b1;
    end
    if (b == CH_CR) begin
      cr_seen_q = 1'b1;
      return 1'b0;
    end
    if (b == CH_LF) begin
      if (!cr_seen_q) return 1'b0;
      if (ph == PH_KEY) begin
        {ends, next_ph, done} = {1'b1, PH_BODY, 1'b1};
      end else if (ph == PH_TEXT || ph == PH_VALUE ||
                   (ph == PH_MINOR && kind_q == KIND_REQUEST)) begin
        {ends, next_ph} = {1'b1, PH_KEY};
      end else begin
        return 1'b0;
      end
    end else begin
      case (ph)
        PH_METHOD: if (b == CH_SPACE) {ends, next_ph} = {1'b1, PH_URI};
        PH_URI: begin
          if (b == CH_SPACE) begin
            {ends, next_ph} = {1'b1, PH_PROTO};
          end else if (b == CH_QMARK && !in_query_q) begin
            in_query_q      = 1'b1;
            {ends, next_ph} = {1'b1, PH_QUERY};
          end
        end
        PH_QUERY: if (b == CH_SPACE) {ends, next_ph} = {1'b1, PH_PROTO};
        PH_PROTO: if (b == CH_SLASH) {ends, next_ph} = {1'b1, PH_MAJOR};
        PH_MAJOR: begin
          if (b == CH_DOT) {ends, next_ph} = {1'b1, PH_MINOR};
          else add_digit(b);
        end
        PH_MINOR: begin
          if (b == CH_SPACE && kind_q == KIND_RESPONSE) {ends, next_ph} = {1'b1, PH_STATUS};
          else add_digit(b);
        end
        PH_STATUS: begin
          if (b == CH_SPACE) {ends, next_ph} = {1'b1, PH_TEXT};
          else add_digit(b);
        end
        PH_KEY: if (b == CH_COLON) {ends, next_ph} = {1'b1, PH_VALUE};
        default: ;
      endcase
    end
    if (ends) begin
      tok.field_tag        = ph;
      tok.is_content       = 1'b0;
      tok.headers_complete = done;
      if (ph == PH_MAJOR || ph == PH_MINOR || ph == PH_STATUS)
        tok.numeric_value = acc_q[NUMERIC_W-1:0];
      acc_q     = '0;
      stopped_q = 1'b0;
      phase_q   = next_ph;
    end else begin
      tok.out_byte   = b;
      tok.field_tag  = ph;
      tok.is_content = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned field_mismatch(input string name,
                                                 input logic [15:0] want,
                                                 input logic [15:0] got);
    if (want === got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_t want;
    token_t predicted;
    if (!rst_ni) begin
      kind_q     = KIND_REQUEST;
      phase_q    = PH_METHOD;
      cr_seen_q  = 1'b0;
      in_query_q = 1'b0;
      acc_q      = '0;
      stopped_q  = 1'b0;
      expected_tokens.delete();
      pending_o <= 0;
      errors_o  <= err_count;
    end else begin
      // Compare first: a token seen now comes from a byte taken on an earlier edge
      if (token_mon.valid && token_mon.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token with no byte to account for it: tag %0d byte %0d",
                 token_mon.field_tag, token_mon.out_byte);
          err_count++;
        end else begin
          want = expected_tokens.pop_front();
          err_count += field_mismatch("out_byte", 16'(want.out_byte), 16'(token_mon.out_byte));
          err_count += field_mismatch("field_tag", 16'(want.field_tag),
                                      16'(token_mon.field_tag));
          err_count += field_mismatch("is_content", 16'(want.is_content),
                                      16'(token_mon.is_content));
          err_count += field_mismatch("numeric_value", 16'(want.numeric_value),
                                      16'(token_mon.numeric_value));
          err_count += field_mismatch("headers_complete", 16'(want.headers_complete),
                                      16'(token_mon.headers_complete));
        end
      end
      if (cfg_wr_en_i) kind_q = cfg_wr_data_i;
      if (byte_mon.valid && byte_mon.ready) begin
        if (tokenize_byte(byte_mon.in_byte, byte_mon.start_of_message, predicted))
          expected_tokens.push_back(predicted);
      end
      pending_o <= expected_tokens.size();
      errors_o  <= err_count;
    end
  end

endmodule

@@ bench/http_header_tokenizer_tb.sv @@
`timescale 1ns / 1ps

// Drives HTTP message bytes into the tokenizer and lets the checker beside it
// predict and compare every token. A short directed walk covers delimiter
// corner cases and mid-message kind changes; the random part is mostly
// well-formed requests and responses with random content, plus truncated,
// corrupted and pure-noise byte streams.
module http_header_tokenizer_tb;
  import hht_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  // Worst case is far below this: ~2k bytes, each with a long gap and a long stall
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  logic clk_i;
  logic rst_ni;
  logic cfg_wr_en_i;
  logic cfg_wr_data_i;

  hht_in_if  in_if ();
  hht_out_if out_if ();

  int unsigned pending_tokens;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;

  // Steady flags switch off idling on one side for a whole phase
  bit         source_steady = 1'b0;
  bit         sink_steady   = 1'b0;
  logic       cur_kind      = KIND_REQUEST;
  logic [7:0] msg_bytes[$];

  http_header_tokenizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_i          (in_if),
    .out_o         (out_if)
  );

  http_header_tokenizer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .byte_mon      (in_if),
    .token_mon     (out_if),
    .pending_o     (pending_tokens),
    .errors_o      (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on a handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("http_header_tokenizer_tb failed");
      $finish;
    end
  end

  // Idle length: mostly from the short band, sometimes the middle, rarely the long one
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Output side: alternate runs of ready high and stalls of random length
  initial begin
    bit          high_run;
    int unsigned run_left;
    high_run = 1'b1;
    run_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        high_run = sink_steady || ($urandom_range(0, 2) != 0);
        run_left = high_run ? $urandom_range(1, 16) : pause_len();
      end
      out_if.ready <= high_run;
      run_left--;
    end
  end

  // Offer one byte and hold it until the transfer. Valid stays high afterwards
  // so back-to-back bytes need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int unsigned gap;
    gap = (source_steady || $urandom_range(0, 99) < 55) ? 0 : pause_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.in_byte          <= b;
    in_if.start_of_message <= restart;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic restart);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], restart && i == 0);
  endtask

  // Drain every token, give the block time to settle, then write the kind
  task automatic set_kind(input logic kind);
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_tokens != 0);
    repeat (3) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= kind;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    cur_kind = kind;
  endtask

  // Message builders append to msg_bytes
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic add_word(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    repeat ($urandom_range(lo, hi)) begin
      r = $urandom_range(0, 51);
      msg_bytes.push_back((r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26));
    end
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // Version and status digits: empty, short, often long enough to saturate, or cut by junk
  task automatic add_digits();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return;
    if (r < 75) begin
      repeat ($urandom_range(1, 3)) msg_bytes.push_back(rand_digit());
    end else if (r < 90) begin
      repeat ($urandom_range(5, 9)) msg_bytes.push_back(rand_digit());
    end else begin
      repeat ($urandom_range(1, 2)) msg_bytes.push_back(rand_digit());
      add_word(1, 1);
      repeat ($urandom_range(1, 2)) msg_bytes.push_back(rand_digit());
    end
  endtask

  // CR LF mostly; a bare LF still ends the line once any CR has been seen
  task automatic add_eol();
    if ($urandom_range(0, 9) != 0) msg_bytes.push_back(CH_CR);
    msg_bytes.push_back(CH_LF);
  endtask

  // Bytes biased toward the delimiters the parser reacts to
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 15))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_SPACE;
      3:       return CH_SLASH;
      4:       return CH_DOT;
      5:       return CH_COLON;
      6:       return CH_QMARK;
      7:       return rand_digit();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_message(input logic kind);
    if (kind == KIND_REQUEST) begin
      add_word(1, 6);
      msg_bytes.push_back(CH_SPACE);
      msg_bytes.push_back(CH_SLASH);
      add_word(0, 5);
      if ($urandom_range(0, 1) != 0) begin
        msg_bytes.push_back(CH_QMARK);
        add_word(0, 4);
        if ($urandom_range(0, 2) == 0) begin
          msg_bytes.push_back(CH_QMARK);
          add_word(0, 3);
        end
      end
      msg_bytes.push_back(CH_SPACE);
      add_text("HTTP");
      msg_bytes.push_back(CH_SLASH);
      add_digits();
      msg_bytes.push_back(CH_DOT);
      add_digits();
    end else begin
      add_text("HTTP");
      msg_bytes.push_back(CH_SLASH);
      add_digits();
      msg_bytes.push_back(CH_DOT);
      add_digits();
      msg_bytes.push_back(CH_SPACE);
      add_digits();
      msg_bytes.push_back(CH_SPACE);
      add_word(0, 6);
      if ($urandom_range(0, 1) != 0) begin
        msg_bytes.push_back(CH_SPACE);
        add_word(1, 4);
      end
    end
    add_eol();
    repeat ($urandom_range(0, 3)) begin
      add_word(1, 8);
      msg_bytes.push_back(CH_COLON);
      msg_bytes.push_back(CH_SPACE);
      add_word(0, 8);
      add_eol();
    end
    add_eol();
    repeat ($urandom_range(0, 10)) msg_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Restart on the first byte when asked; sprinkle stray restarts on noisy streams
  task automatic send_message(input logic restart, input bit noisy);
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], (restart && i == 0) || (noisy && $urandom_range(0, 15) == 0));
  endtask

  initial begin
    int unsigned r;
    int unsigned k;
    rst_ni                 <= 1'b0;
    cfg_wr_en_i            <= 1'b0;
    cfg_wr_data_i          <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.in_byte          <= 8'h00;
    in_if.start_of_message <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk, request kind from reset. An LF before any CR is dropped;
    // then method bytes at both ends of the range, a URI with a first question
    // mark that opens the query and a second that stays in it, a major that
    // saturates, a minor cut short by junk, an empty key, a value line and the
    // empty line into the body, where even CR is content.
    send_byte(CH_LF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text(" /a?b? HTTP/9999999.1x2\r\n:v\r\n\r\n\r", 1'b0);

    // Response status line, then a key with a colon and the empty line
    set_kind(KIND_RESPONSE);
    send_text("HTTP/1.1 404 No\r\nk:\r\n\r\n", 1'b1);

    // Kind flips mid-message: only the minor delimiter follows the new kind
    send_text("HTTP/1.", 1'b1);
    set_kind(KIND_REQUEST);
    send_text("0 2\r\n\r\n", 1'b0);
    send_text("G / H/1.", 1'b1);
    set_kind(KIND_RESPONSE);
    send_text("1 7 x\n\n", 1'b0);

    // Random phases: new kind and idling style per phase, a few streams each
    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      set_kind(logic'($urandom_range(0, 1)));
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        msg_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // Well-formed; now and then carry on without a restart
          build_message(cur_kind);
          send_message($urandom_range(0, 19) != 0, 1'b0);
        end else if (r < 85) begin
          // Broken: truncate, or overwrite a few bytes with delimiters and junk
          build_message(cur_kind);
          if ($urandom_range(0, 1) != 0) begin
            k = $urandom_range(1, msg_bytes.size());
            msg_bytes = msg_bytes[0:k-1];
          end else begin
            repeat ($urandom_range(1, 3))
              msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = noise_byte();
          end
          send_message(1'b1, 1'b0);
        end else begin
          repeat ($urandom_range(3, 20)) msg_bytes.push_back(noise_byte());
          send_message($urandom_range(0, 1) != 0, 1'b1);
        end
      end
    end

    // Drop valid, wait for the last token, then let the pipeline settle
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_tokens != 0);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("http_header_tokenizer_tb passed");
    end else begin
      $display("http_header_tokenizer_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/hht_pkg.sv
src/hht_in_if.sv
src/hht_out_if.sv
src/hht_step.sv
src/http_header_tokenizer.sv
bench/http_header_tokenizer_checker.sv
bench/http_header_tokenizer_tb.sv
